FILE: rtl/prba_pkg.sv
// Package: shared types, codes and state encoding of the page run bitmap allocator.
`default_nettype none
package prba_pkg;

    localparam logic [1:0] OP_ALLOC_ONE = 2'd0;
    localparam logic [1:0] OP_ALLOC_RUN = 2'd1;
    localparam logic [1:0] OP_FREE_RUN  = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    localparam int REG_WINDOW_BASE = 0;

    typedef struct packed {
        logic [1:0]  operation;
        logic [10:0] page_count;
        logic [31:0] free_address;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  page_index;
        logic [31:0] page_address;
    } rsp_t;

    typedef struct packed {
        logic        start;
        logic [31:0] num;
    } div_cmd_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
    } div_res_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_FCHECK,
        S_SCAN,
        S_MOD_RD,
        S_MOD_WR,
        S_RESULT
    } state_t;

endpackage
`default_nettype wire

FILE: rtl/prba_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module prba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/prba_cfg.sv
// APB register file holding the window base address.
`default_nettype none
module prba_cfg
    import prba_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output logic      [31:0] window_base
);
    logic [31:0] base_reg;
    logic        hit;

    assign hit         = (paddr[2] == 1'(REG_WINDOW_BASE));
    assign pready      = 1'b1;
    assign window_base = base_reg;
    assign prdata      = hit ? base_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= 32'd0;
        end
        else if (psel && penable && pwrite && hit)
        begin
            base_reg <= pwdata;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/prba_div.sv
// Page number from a byte offset: divide by the power-of-two page size with a shift.
`default_nettype none
module prba_div
    import prba_pkg::*;
#(
    parameter int DIVISOR = 4096
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_cmd_t cmd,
    output div_res_t      res
);
    localparam int SH = $clog2(DIVISOR);

    logic [31:0] quo_reg, quo_next;
    logic        done_reg, done_next;

    assign res.done = done_reg;
    assign res.quo  = quo_reg;

    always_comb
    begin
        quo_next  = quo_reg;
        done_next = 1'b0;
        if (cmd.start)
        begin
            // page size is a power of two: drop the in-page offset bits
            quo_next  = cmd.num >> SH;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
    end
endmodule
`default_nettype wire

FILE: rtl/page_run_bitmap_allocator.sv
// Top level: next-fit page run allocator over a byte-wide usage bitmap memory.
//
// Usage: the request channel (req_valid/req_ready, req) takes one word per
// operation: allocate one page, allocate a run of page_count pages, or free
// a run starting at free_address. Each request yields exactly one response
// word on rsp_valid/rsp_ready with status, first page index and address.
// Only one request is in flight; req_ready is high whenever the controller
// is idle, even while the previous response still waits in its register.
// Flow: a rejected request goes straight from idle to the result state.
// An allocation streams the bitmap memory at one byte (8 pages) per cycle
// from the hint to the end, and again from page 0 on wrap, then
// read-modify-writes each touched byte, a read state then a write state.
// A free turns the offset into a page number, checks the range, then
// read-modify-writes each touched byte the same way.
// Reset: the window base and hint clear at once; the bitmap memory is then
// swept to zero one byte per cycle before the first request is taken. APB
// writes are taken at any time.
// Stall: while rsp_ready is low the response holds and a finished request
// waits before loading its result.
`default_nettype none
module page_run_bitmap_allocator
    import prba_pkg::*;
#(
    parameter int MAP_PAGES  = 1024,
    parameter int PAGE_BYTES = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_ready,
    input  wire req_t        req,
    output logic             rsp_valid,
    input  wire logic        rsp_ready,
    output rsp_t             rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    // bitmap geometry: 8 pages per memory byte, tail padding reads as used
    localparam int NB = (MAP_PAGES + 7) / 8;
    localparam int AW = $clog2(NB);
    localparam int XW = $clog2(NB * 8 + 1);

    logic [31:0] window_base;

    prba_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .window_base (window_base)
    );

    div_cmd_t div_cmd;
    div_res_t div_res;

    prba_div #(.DIVISOR(PAGE_BYTES)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .res   (div_res)
    );

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;

    prba_ram #(.WIDTH(8), .DEPTH(NB)) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // control state
    state_t        state_reg, state_next;
    logic [XW-1:0] hint_reg, hint_next;
    logic          rsp_valid_reg, rsp_valid_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic          dv_reg, dv_next;          // scan read data valid
    logic          issued_reg, issued_next;  // last byte of pass already read

    // working registers
    logic [1:0]    op_reg, op_next;
    logic [XW-1:0] n_reg, n_next;
    logic [10:0]   count_reg, count_next;
    logic [XW-1:0] lo_reg, lo_next;          // scan floor, then run first page
    logic [XW-1:0] hi_reg, hi_next;          // run last page
    logic [XW-1:0] run_reg, run_next;
    logic          pass1_reg, pass1_next;
    logic [AW-1:0] rd_addr_reg, rd_addr_next;
    logic [AW-1:0] data_addr_reg, data_addr_next;
    logic [AW-1:0] mod_addr_reg, mod_addr_next;
    rsp_t          res_reg, res_next;
    rsp_t          rsp_reg, rsp_next;

    // byte scan results
    logic [XW-1:0] sc_run;
    logic          sc_found;
    logic [XW-1:0] sc_at;
    logic [XW-1:0] sc_idx;
    logic          sc_used;
    logic [7:0]    mod_mask;
    logic [XW-1:0] start_idx;
    logic          accept;
    logic          req_bad_run;
    logic [31:0]   quo;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign quo       = div_res.quo;

    assign start_idx = (hint_reg < XW'(MAP_PAGES)) ? hint_reg : '0;

    // walk the 8 pages of the byte in flight, carrying the clear run length
    always_comb
    begin
        sc_run   = run_reg;
        sc_found = 1'b0;
        sc_at    = '0;
        sc_idx   = '0;
        sc_used  = 1'b0;
        for (int j = 0; j < 8; j++)
        begin
            sc_idx  = XW'({data_addr_reg, 3'(j)});
            sc_used = ram_rdata[j] || (sc_idx < lo_reg) || (sc_idx >= XW'(MAP_PAGES));
            sc_run  = sc_used ? '0 : sc_run + XW'(1);
            if (!sc_found && (sc_run == n_reg))
            begin
                sc_found = 1'b1;
                sc_at    = sc_idx + XW'(1) - n_reg;
            end
        end
    end

    // pages of the current byte that fall inside [lo, hi]
    always_comb
    begin
        for (int j = 0; j < 8; j++)
        begin
            mod_mask[j] = (XW'({mod_addr_reg, 3'(j)}) >= lo_reg)
                       && (XW'({mod_addr_reg, 3'(j)}) <= hi_reg);
        end
    end

    always_comb
    begin
        req_bad_run = (req.page_count == 11'd0)
                   || (32'(req.page_count) > 32'(MAP_PAGES));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_addr_reg == AW'(NB - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.operation)
                        OP_ALLOC_ONE:
                        begin
                            state_next = S_SCAN;
                        end
                        OP_ALLOC_RUN:
                        begin
                            state_next = req_bad_run ? S_RESULT : S_SCAN;
                        end
                        OP_FREE_RUN:
                        begin
                            state_next = (req_bad_run || (req.free_address < window_base))
                                       ? S_RESULT : S_DIV;
                        end
                        default:
                        begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                if (div_res.done)
                begin
                    state_next = S_FCHECK;
                end
            end
            S_FCHECK:
            begin
                if ((quo < 32'(MAP_PAGES))
                    && (32'(count_reg) <= 32'(MAP_PAGES) - quo))
                begin
                    state_next = S_MOD_RD;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_SCAN:
            begin
                if (dv_reg)
                begin
                    if (sc_found)
                    begin
                        state_next = S_MOD_RD;
                    end
                    else if ((data_addr_reg == AW'(NB - 1))
                             && !(pass1_reg && (lo_reg != '0)))
                    begin
                        state_next = S_RESULT;
                    end
                end
            end
            S_MOD_RD:
            begin
                state_next = S_MOD_WR;
            end
            S_MOD_WR:
            begin
                state_next = (mod_addr_reg == AW'(hi_reg >> 3)) ? S_RESULT : S_MOD_RD;
            end
            S_RESULT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        hint_next      = hint_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        clr_addr_next  = clr_addr_reg;
        dv_next        = 1'b0;
        issued_next    = issued_reg;
        op_next        = op_reg;
        n_next         = n_reg;
        count_next     = count_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        run_next       = run_reg;
        pass1_next     = pass1_reg;
        rd_addr_next   = rd_addr_reg;
        data_addr_next = data_addr_reg;
        mod_addr_next  = mod_addr_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        ram_waddr      = mod_addr_reg;
        ram_wdata      = ram_rdata;
        ram_raddr      = rd_addr_reg;
        div_cmd.start  = 1'b0;
        div_cmd.num    = req.free_address - window_base;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = 8'd0;
                clr_addr_next = clr_addr_reg + AW'(1);
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = req.operation;
                    count_next = req.page_count;
                    n_next     = (req.operation == OP_ALLOC_ONE) ? XW'(1) : XW'(req.page_count);
                    res_next   = '{status: ST_BAD, page_index: 10'd0, page_address: 32'd0};
                    // first pass of the search starts at the hint
                    lo_next      = start_idx;
                    run_next     = '0;
                    pass1_next   = 1'b1;
                    issued_next  = 1'b0;
                    rd_addr_next = AW'(start_idx >> 3);
                    div_cmd.start = (req.operation == OP_FREE_RUN);
                end
            end
            S_FCHECK:
            begin
                lo_next       = XW'(quo);
                hi_next       = XW'(quo) + XW'(count_reg) - XW'(1);
                mod_addr_next = AW'(quo >> 3);
            end
            S_SCAN:
            begin
                ram_raddr = rd_addr_reg;
                if (!issued_reg)
                begin
                    dv_next        = 1'b1;
                    data_addr_next = rd_addr_reg;
                    if (rd_addr_reg == AW'(NB - 1))
                    begin
                        issued_next = 1'b1;
                    end
                    else
                    begin
                        rd_addr_next = rd_addr_reg + AW'(1);
                    end
                end
                if (dv_reg)
                begin
                    run_next = sc_run;
                    if (sc_found)
                    begin
                        dv_next       = 1'b0;
                        lo_next       = sc_at;
                        hi_next       = sc_at + n_reg - XW'(1);
                        mod_addr_next = AW'(sc_at >> 3);
                    end
                    else if (data_addr_reg == AW'(NB - 1))
                    begin
                        dv_next = 1'b0;
                        if (pass1_reg && (lo_reg != '0))
                        begin
                            // wrap: search again from page 0
                            pass1_next   = 1'b0;
                            lo_next      = '0;
                            run_next     = '0;
                            issued_next  = 1'b0;
                            rd_addr_next = '0;
                        end
                        else
                        begin
                            res_next.status = ST_FULL;
                        end
                    end
                end
            end
            S_MOD_RD:
            begin
                ram_raddr = mod_addr_reg;
            end
            S_MOD_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = mod_addr_reg;
                ram_wdata = (op_reg == OP_FREE_RUN) ? (ram_rdata & ~mod_mask)
                                                    : (ram_rdata | mod_mask);
                mod_addr_next = mod_addr_reg + AW'(1);
                if (mod_addr_reg == AW'(hi_reg >> 3))
                begin
                    if (op_reg == OP_FREE_RUN)
                    begin
                        res_next.status = ST_OK;
                        if (lo_reg < hint_reg)
                        begin
                            hint_next = lo_reg;
                        end
                    end
                    else
                    begin
                        res_next.status       = ST_OK;
                        res_next.page_index   = 10'(lo_reg);
                        res_next.page_address = window_base
                                              + 32'(32'(lo_reg) * 32'(PAGE_BYTES));
                        if (op_reg == OP_ALLOC_ONE)
                        begin
                            hint_next = lo_reg + XW'(1);
                        end
                        else if (hint_reg == lo_reg)
                        begin
                            hint_next = hint_reg + n_reg;
                        end
                    end
                end
            end
            S_RESULT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            hint_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            clr_addr_reg  <= '0;
            dv_reg        <= 1'b0;
            issued_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hint_reg      <= hint_next;
            rsp_valid_reg <= rsp_valid_next;
            clr_addr_reg  <= clr_addr_next;
            dv_reg        <= dv_next;
            issued_reg    <= issued_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        n_reg         <= n_next;
        count_reg     <= count_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        run_reg       <= run_next;
        pass1_reg     <= pass1_next;
        rd_addr_reg   <= rd_addr_next;
        data_addr_reg <= data_addr_next;
        mod_addr_reg  <= mod_addr_next;
        res_reg       <= res_next;
        rsp_reg       <= rsp_next;
    end
endmodule
`default_nettype wire
